### design/dvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvs_pkg
// shared widths and item/result types for the per-chain value set
// ----------------------------------------------------------------------------
package dvs_pkg;

    localparam int CHAIN_W     = 7;
    localparam int WORD_W      = 64;
    localparam int MAX_WORDS   = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int TOTAL_OUT_W = 11;

    // classified request handed from the front to the back
    typedef struct packed {
        logic [CHAIN_W-1:0]                  chain;
        logic                                in_range;
        logic [MAX_WORDS-1:0][WORD_W-1:0]    words;
    } t_item;

    typedef struct packed {
        logic [CHAIN_W-1:0]     chain_echo;
        logic                   was_new;
        logic                   dropped_full;
        logic [COUNT_OUT_W-1:0] chain_count;
        logic [TOTAL_OUT_W-1:0] total_count;
    } t_result;

endpackage
`default_nettype wire

### design/dvs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvs_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface dvs_in_if import dvs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAIN_W-1:0] chain_index;
    logic [WORD_W-1:0]  word0;
    logic [WORD_W-1:0]  word1;
    logic [WORD_W-1:0]  word2;
    logic [WORD_W-1:0]  word3;

    modport source (output valid, chain_index, word0, word1, word2, word3, input ready);
    modport sink   (input valid, chain_index, word0, word1, word2, word3, output ready);
endinterface

interface dvs_out_if import dvs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CHAIN_W-1:0]     chain_echo;
    logic                   was_new;
    logic                   dropped_full;
    logic [COUNT_OUT_W-1:0] chain_count;
    logic [TOTAL_OUT_W-1:0] total_count;

    modport source (output valid, chain_echo, was_new, dropped_full, chain_count,
                    total_count, input ready);
    modport sink   (input valid, chain_echo, was_new, dropped_full, chain_count,
                    total_count, output ready);
endinterface
`default_nettype wire

### design/dvs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvs_front
// input register: takes requests and tags them with the chain range check
// ----------------------------------------------------------------------------
module dvs_front import dvs_pkg::*; #(
    parameter int NUM_CHAINS = 67
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    dvs_in_if.sink i_in,
    output t_item  o_item,
    output logic   o_push,
    input  wire    i_push_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_item.chain    = i_in.chain_index;
        n_item.in_range = ({1'b0, i_in.chain_index} < (CHAIN_W+1)'(NUM_CHAINS));
        n_item.words[0] = i_in.word0;
        n_item.words[1] = i_in.word1;
        n_item.words[2] = i_in.word2;
        n_item.words[3] = i_in.word3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
    assign o_push = r_valid;

endmodule
`default_nettype wire

### design/dvs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module dvs_queue import dvs_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  wire   i_pop
);

    t_item       r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;
    logic        do_push;
    logic        do_pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_entry[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### design/dvs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvs_back
// per-request lookup: count read, slot scan, append and result register
// ----------------------------------------------------------------------------
module dvs_back import dvs_pkg::*; #(
    parameter int NUM_CHAINS  = 67,
    parameter int CHAIN_DEPTH = 16,
    parameter int VALUE_WORDS = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    dvs_out_if.source  o_out
);

    localparam int CW  = $clog2(CHAIN_DEPTH + 1);
    localparam int SW  = $clog2(CHAIN_DEPTH);
    localparam int TW  = $clog2(NUM_CHAINS * CHAIN_DEPTH + 1);
    localparam int AW  = $clog2(NUM_CHAINS * CHAIN_DEPTH);
    localparam int CIW = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
    localparam int VW  = VALUE_WORDS * WORD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CNT  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]            r_state, n_state;
    t_item                 r_item;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_base;
    logic [SW-1:0]         r_slot, n_slot;
    logic                  r_hit, n_hit;
    logic [TW-1:0]         r_total;
    logic [NUM_CHAINS-1:0] r_cnt_vld;
    logic [CW-1:0]         r_cnt_mem [NUM_CHAINS];
    logic [CW-1:0]         r_cnt_rd;
    logic                  r_cnt_rd_vld;
    logic [VW-1:0]         r_val_mem [NUM_CHAINS * CHAIN_DEPTH];
    logic [VW-1:0]         r_val_rd;
    logic                  r_out_valid;
    t_result               r_out;

    logic [VW-1:0]         item_val;
    logic [CW-1:0]         count_now;
    logic                  val_re;
    logic [AW-1:0]         val_raddr;
    logic                  out_free;
    logic                  fin_go;
    logic                  room;
    logic                  append;
    logic [CIW-1:0]        head_idx;
    logic [CIW-1:0]        item_idx;
    logic [AW-1:0]         head_base;
    t_result               res;

    for (genvar w = 0; w < VALUE_WORDS; w++) begin : g_val
        assign item_val[w*WORD_W +: WORD_W] = r_item.words[w];
    end

    assign head_idx  = CIW'(i_q_item.chain);
    assign item_idx  = CIW'(r_item.chain);
    assign head_base = AW'(32'(i_q_item.chain) * CHAIN_DEPTH);
    assign count_now = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
    assign out_free  = !r_out_valid || o_out.ready;
    assign fin_go    = (r_state == ST_FIN) && out_free;
    assign room      = (r_count < CW'(CHAIN_DEPTH));
    assign append    = fin_go && r_item.in_range && !r_hit && room;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_slot    = r_slot;
        n_hit     = r_hit;
        val_re    = 1'b0;
        val_raddr = r_base;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_count = '0;
                    n_hit   = 1'b0;
                    n_state = i_q_item.in_range ? ST_CNT : ST_FIN;
                end
            end
            ST_CNT: begin
                n_count = count_now;
                n_slot  = '0;
                if (count_now == '0) begin
                    n_state = ST_FIN;
                end else begin
                    val_re  = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_val_rd == item_val) begin
                    n_hit   = 1'b1;
                    n_state = ST_FIN;
                end else if (CW'(r_slot) + CW'(1) == r_count) begin
                    n_state = ST_FIN;
                end else begin
                    val_re    = 1'b1;
                    val_raddr = r_base + AW'(r_slot) + AW'(1);
                    n_slot    = r_slot + SW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.chain_echo   = r_item.chain;
        res.was_new      = r_item.in_range && !r_hit;
        res.dropped_full = r_item.in_range && !r_hit && !room;
        res.chain_count  = COUNT_OUT_W'(r_count + CW'(append));
        res.total_count  = TOTAL_OUT_W'(r_total + TW'(append));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_cnt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (append) begin
                r_total             <= r_total + TW'(1);
                r_cnt_vld[item_idx] <= 1'b1;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_slot  <= n_slot;
        r_hit   <= n_hit;
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_base <= head_base;
        end
        if (fin_go) begin
            r_out <= res;
        end
    end

    // chain count store
    always_ff @(posedge i_clk) begin
        if (append) begin
            r_cnt_mem[item_idx] <= r_count + CW'(1);
        end
        if (o_q_pop && i_q_item.in_range) begin
            r_cnt_rd     <= r_cnt_mem[head_idx];
            r_cnt_rd_vld <= r_cnt_vld[head_idx];
        end
    end

    // value store, one row per slot
    always_ff @(posedge i_clk) begin
        if (append) begin
            r_val_mem[r_base + AW'(r_count[SW-1:0])] <= item_val;
        end
        if (val_re) begin
            r_val_rd <= r_val_mem[val_raddr];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.chain_echo   = r_out.chain_echo;
    assign o_out.was_new      = r_out.was_new;
    assign o_out.dropped_full = r_out.dropped_full;
    assign o_out.chain_count  = r_out.chain_count;
    assign o_out.total_count  = r_out.total_count;

endmodule
`default_nettype wire

### design/dedup_value_set_per_chain.sv
// the back handles one request at a time: pop, count read, one stored slot per cycle on
// the single value store read port, finish; a chain out of range or with no stored values
// skips the scan, and the scan stops at a match or when all of the chain's slots are scanned
// reset: synchronous active low, clears all chain counts and the total at once;
// no clearing pass, the value store is only read below a chain's count
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_value_set_per_chain
// keeps a set of distinct values per chain, appends new ones, reports counts
// ----------------------------------------------------------------------------
module dedup_value_set_per_chain import dvs_pkg::*; #(
    parameter int NUM_CHAINS  = 67,
    parameter int CHAIN_DEPTH = 16,
    parameter int VALUE_WORDS = 4
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dvs_in_if.sink    i_in,
    dvs_out_if.source o_out
);

    // front to queue
    t_item front_item;
    logic  front_push;
    logic  q_ready;

    // queue to back
    t_item q_item;
    logic  q_valid;
    logic  q_pop;

    // front: registers each request and flags chains beyond the range
    dvs_front #(
        .NUM_CHAINS (NUM_CHAINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (front_item),
        .o_push       (front_push),
        .i_push_ready (q_ready)
    );

    // short queue so the front keeps taking requests while the back scans
    dvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // back: count lookup, slot-by-slot compare, append and result register
    dvs_back #(
        .NUM_CHAINS  (NUM_CHAINS),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .VALUE_WORDS (VALUE_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire
